// ===== rtl/tape_byte_pulse_encoder_core_assert.svh =====
// Assertion macros used by the checker module of the tape pulse encoder.
`ifndef TAPE_BYTE_PULSE_ENCODER_CORE_ASSERT_SVH
`define TAPE_BYTE_PULSE_ENCODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBPE_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("tbpe assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TBPE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("tbpe assertion failed");

`endif

// ===== rtl/tbpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tbpe_pkg;

	localparam logic [7:0] LevelHigh = 8'hFF;
	localparam logic [7:0] LevelLow  = 8'h7F;

	localparam logic [4:0] ShortWhole = 5'd9;
	localparam logic [4:0] LongWhole  = 5'd18;
	localparam logic [14:0] ShortFrac = 15'd405;
	localparam logic [14:0] LongFrac  = 15'd810;
	localparam logic [14:0] FracOne   = 15'd10000;

	localparam logic [3:0] FrameBits = 4'd12;
	localparam logic [3:0] ParityIdx = 4'd9;
	localparam logic [3:0] LastDataIdx = 4'd8;

	localparam logic [4:0] FastSegs    = 5'd2;
	localparam logic [4:0] SlowOneSegs  = 5'd16;
	localparam logic [4:0] SlowZeroSegs = 5'd8;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef struct packed {
		logic       step;
		cmd_t       cmd;
		logic [7:0] data_byte;
	} step_req_t;

	typedef struct packed {
		logic [7:0] sample_value;
		logic       byte_done;
		logic       underrun;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/tape_byte_pulse_encoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Cassette tape pulse encoder: turns bytes into 44.1 kHz audio samples.
// Input stream: s_axis_tuser selects the command, 0 loads s_axis_tdata as a
// byte to send and 1 asks for one sample. A load produces no output transfer;
// a load that arrives while a byte is still being sent is dropped.
// Output stream: one transfer per sample request, carrying the sample level
// (0xFF high, 0x7F low), tlast on the final sample of a byte's frame and
// tuser set when the request found no byte to send.
// The user must set the encoding mode through cfg_we and cfg_wdata only
// while the block idles; the block does not enforce this. An input transfer
// passes the input register, then the state update and result register.
// Input takes one transfer per cycle unless a sample request waits on a
// stalled output; the only loop updates bit, segment and sample counters.
// A full result register with the receiver stalled holds its transfer; the
// input register still takes a further transfer and then waits for the
// output to drain, while loads keep passing as they need no output slot.
// Reset returns the encoder to idle with no byte loaded, clears the fraction
// accumulator and selects slow mode.
module tape_byte_pulse_encoder_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire        cfg_wdata,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,  // data_byte[7:0]
	input  wire  [0:0] s_axis_tuser,  // cmd[0]
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,  // sample_value[7:0]
	output logic       m_axis_tlast,
	output logic [0:0] m_axis_tuser   // underrun[0]
);

	logic                fast_mode_q;
	logic                valid_s1;
	tbpe_pkg::cmd_t      cmd_s1;
	logic [7:0]          data_s1;
	logic                valid_s2;
	tbpe_pkg::result_t   res_s2;

	logic                out_free;
	logic                advance;
	tbpe_pkg::step_req_t req;
	tbpe_pkg::result_t   res;

	assign out_free = !valid_s2 || m_axis_tready;
	assign advance  = valid_s1 && ((cmd_s1 == tbpe_pkg::CMD_LOAD) || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	assign req.step      = advance;
	assign req.cmd       = cmd_s1;
	assign req.data_byte = data_s1;

	tbpe_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.fast_mode (fast_mode_q),
		.req       (req),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_mode_q <= 1'b0;
		end else if (cfg_we) begin
			fast_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= tbpe_pkg::cmd_t'(s_axis_tuser[0]);
			data_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && (cmd_s1 == tbpe_pkg::CMD_TICK);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && (cmd_s1 == tbpe_pkg::CMD_TICK)) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid   = valid_s2;
	assign m_axis_tdata    = res_s2.sample_value;
	assign m_axis_tlast    = res_s2.byte_done;
	assign m_axis_tuser[0] = res_s2.underrun;

endmodule

`default_nettype wire

// ===== rtl/tbpe_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tbpe_engine (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      fast_mode,
	input  wire tbpe_pkg::step_req_t req,
	output tbpe_pkg::result_t        res
);

	logic [7:0]  shift_byte_q;
	logic        parity_bit_q;
	logic [3:0]  frame_idx_q;
	logic [3:0]  half_idx_q;
	logic [4:0]  samples_left_q;
	logic [14:0] frac_acc_q;
	logic        busy_q;

	logic        cur_bit;
	logic [3:0]  idx_m1;
	logic [4:0]  segs;
	logic        is_long;
	logic        seg_start;
	logic        carry;
	logic [4:0]  seg_len;
	logic [14:0] frac_next;
	logic [4:0]  sl_cur;
	logic [4:0]  sl_next;
	logic        seg_end;
	logic        bit_end;
	logic [3:0]  frame_inc;
	logic        frame_end;
	logic        parity_new;

	assign idx_m1 = frame_idx_q - 4'd1;

	always_comb begin
		if (frame_idx_q == 4'd0) begin
			cur_bit = 1'b0;
		end else if (frame_idx_q <= tbpe_pkg::LastDataIdx) begin
			cur_bit = shift_byte_q[idx_m1[2:0]];
		end else if (frame_idx_q == tbpe_pkg::ParityIdx) begin
			cur_bit = parity_bit_q;
		end else begin
			cur_bit = 1'b1;
		end
	end

	always_comb begin
		if (fast_mode) begin
			segs    = tbpe_pkg::FastSegs;
			is_long = half_idx_q[0] & ~cur_bit;
		end else begin
			segs    = cur_bit ? tbpe_pkg::SlowOneSegs : tbpe_pkg::SlowZeroSegs;
			is_long = ~cur_bit;
		end
	end

	assign seg_start = (samples_left_q == 5'd0);
	assign carry     = (frac_acc_q > tbpe_pkg::FracOne);
	assign seg_len   = (is_long ? tbpe_pkg::LongWhole : tbpe_pkg::ShortWhole) + {4'd0, carry};
	assign frac_next = frac_acc_q - (carry ? tbpe_pkg::FracOne : 15'd0)
		+ (is_long ? tbpe_pkg::LongFrac : tbpe_pkg::ShortFrac);
	assign sl_cur    = seg_start ? seg_len : samples_left_q;
	assign sl_next   = sl_cur - 5'd1;
	assign seg_end   = (sl_next == 5'd0);
	assign bit_end   = seg_end && (({1'b0, half_idx_q} + 5'd1) >= segs);
	assign frame_inc = frame_idx_q + 4'd1;
	assign frame_end = bit_end && (frame_inc >= tbpe_pkg::FrameBits);
	assign parity_new = ~(^req.data_byte);

	always_comb begin
		if (busy_q) begin
			res.sample_value = half_idx_q[0] ? tbpe_pkg::LevelLow : tbpe_pkg::LevelHigh;
			res.byte_done    = frame_end;
			res.underrun     = 1'b0;
		end else begin
			res.sample_value = tbpe_pkg::LevelLow;
			res.byte_done    = 1'b0;
			res.underrun     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_byte_q   <= 8'd0;
			parity_bit_q   <= 1'b0;
			frame_idx_q    <= 4'd0;
			half_idx_q     <= 4'd0;
			samples_left_q <= 5'd0;
			frac_acc_q     <= 15'd0;
			busy_q         <= 1'b0;
		end else if (req.step) begin
			if (req.cmd == tbpe_pkg::CMD_LOAD) begin
				if (!busy_q) begin
					shift_byte_q   <= req.data_byte;
					parity_bit_q   <= parity_new;
					frame_idx_q    <= 4'd0;
					half_idx_q     <= 4'd0;
					samples_left_q <= 5'd0;
					busy_q         <= 1'b1;
				end
			end else if (busy_q) begin
				if (seg_start) begin
					frac_acc_q <= frac_next;
				end
				samples_left_q <= sl_next;
				if (bit_end) begin
					half_idx_q <= 4'd0;
					if (frame_end) begin
						frame_idx_q <= 4'd0;
						busy_q      <= 1'b0;
					end else begin
						frame_idx_q <= frame_inc;
					end
				end else if (seg_end) begin
					half_idx_q <= half_idx_q + 4'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tbpe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "tape_byte_pulse_encoder_core_assert.svh"

module tbpe_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tready,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata,
	input wire       m_axis_tlast,
	input wire [0:0] m_axis_tuser
);

	`TBPE_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
	`TBPE_ASSERT_SAME(a_level_code, clk, arst_n, m_axis_tvalid, m_axis_tdata == tbpe_pkg::LevelHigh || m_axis_tdata == tbpe_pkg::LevelLow)
	`TBPE_ASSERT_SAME(a_underrun_low, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == tbpe_pkg::LevelLow && !m_axis_tlast)
	`TBPE_ASSERT_SAME(a_ready_when_drained, clk, arst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind tape_byte_pulse_encoder_core tbpe_checker u_tbpe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== sim/tb_tape_byte_pulse_encoder_core.sv =====
`timescale 1ns / 1ps

module tb_tape_byte_pulse_encoder_core;

	localparam int CycleLimit   = 250000;
	localparam int RandomItems  = 1700;
	localparam int SteadyFirst  = 800;
	localparam int SteadyLast   = 1800;

	class tape_sample_scoreboard;
		tbpe_pkg::result_t expected_samples[$];
		int          errors;
		logic        fast;
		logic [7:0]  shifter;
		logic        parity;
		logic [3:0]  bit_pos;
		logic [3:0]  seg_pos;
		logic [4:0]  remaining;
		logic [14:0] frac;
		logic        sending;

		function new();
			errors    = 0;
			fast      = 1'b0;
			shifter   = '0;
			parity    = 1'b0;
			bit_pos   = '0;
			seg_pos   = '0;
			remaining = '0;
			frac      = '0;
			sending   = 1'b0;
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] error: %s", $realtime, what);
		endtask

		function int pending();
			return expected_samples.size();
		endfunction

		function void set_mode(logic value);
			fast = value;
		endfunction

		// Works out the sample that an accepted transfer must produce, if any.
		function void note_transfer_in(tbpe_pkg::cmd_t cmd, logic [7:0] data);
			tbpe_pkg::result_t exp_res;
			logic       bit_val;
			logic       long_seg;
			logic [4:0] segs;
			logic [4:0] seg_len;
			if (cmd == tbpe_pkg::CMD_LOAD) begin
				if (!sending) begin
					shifter   = data;
					parity    = ~(^data);
					bit_pos   = '0;
					seg_pos   = '0;
					remaining = '0;
					sending   = 1'b1;
				end
				return;
			end
			exp_res = '{sample_value: tbpe_pkg::LevelLow, byte_done: 1'b0, underrun: 1'b1};
			if (sending) begin
				if (bit_pos == 4'd0)
					bit_val = 1'b0;
				else if (bit_pos <= tbpe_pkg::LastDataIdx)
					bit_val = shifter[3'(bit_pos - 4'd1)];
				else if (bit_pos == tbpe_pkg::ParityIdx)
					bit_val = parity;
				else
					bit_val = 1'b1;
				if (fast) begin
					segs     = tbpe_pkg::FastSegs;
					long_seg = seg_pos[0] && !bit_val;
				end else begin
					segs     = bit_val ? tbpe_pkg::SlowOneSegs : tbpe_pkg::SlowZeroSegs;
					long_seg = !bit_val;
				end
				if (remaining == 5'd0) begin
					seg_len = long_seg ? tbpe_pkg::LongWhole : tbpe_pkg::ShortWhole;
					if (frac > tbpe_pkg::FracOne) begin
						seg_len = seg_len + 5'd1;
						frac    = frac - tbpe_pkg::FracOne;
					end
					frac      = frac + (long_seg ? tbpe_pkg::LongFrac : tbpe_pkg::ShortFrac);
					remaining = seg_len;
				end
				exp_res.sample_value = seg_pos[0] ? tbpe_pkg::LevelLow : tbpe_pkg::LevelHigh;
				exp_res.underrun     = 1'b0;
				remaining            = remaining - 5'd1;
				if (remaining == 5'd0) begin
					if ({1'b0, seg_pos} + 5'd1 >= segs) begin
						seg_pos = '0;
						bit_pos = bit_pos + 4'd1;
						if (bit_pos >= tbpe_pkg::FrameBits) begin
							bit_pos           = '0;
							sending           = 1'b0;
							exp_res.byte_done = 1'b1;
						end
					end else begin
						seg_pos = seg_pos + 4'd1;
					end
				end
			end
			expected_samples.insert(expected_samples.size(), exp_res);
		endfunction

		task check_sample(logic [7:0] sample, logic last, logic under);
			tbpe_pkg::result_t exp_res;
			if (expected_samples.size() == 0) begin
				report($sformatf("unexpected sample %02h last %0b underrun %0b",
					sample, last, under));
				return;
			end
			exp_res = expected_samples.pop_front();
			if (sample !== exp_res.sample_value)
				report($sformatf("sample %02h, expected %02h", sample, exp_res.sample_value));
			if (last !== exp_res.byte_done)
				report($sformatf("tlast %0b, expected %0b", last, exp_res.byte_done));
			if (under !== exp_res.underrun)
				report($sformatf("underrun %0b, expected %0b", under, exp_res.underrun));
		endtask
	endclass

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       cfg_we        = 1'b0;
	logic       cfg_wdata     = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = '0;
	logic [0:0] s_axis_tuser  = '0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [0:0] m_axis_tuser;

	int  cycle_count = 0;
	int  item_count;
	logic steady;

	tape_sample_scoreboard sb = new();

	tape_byte_pulse_encoder_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	assign steady = (cycle_count >= SteadyFirst) && (cycle_count < SteadyLast);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("tape_byte_pulse_encoder_core: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_mode(cfg_wdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_sample(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_transfer_in(tbpe_pkg::cmd_t'(s_axis_tuser[0]), s_axis_tdata);
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task send_item(tbpe_pkg::cmd_t cmd, logic [7:0] data);
		while (!steady && $urandom_range(0, 99) < 33) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid   <= 1'b1;
		s_axis_tuser[0] <= cmd;
		s_axis_tdata    <= data;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task drain;
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	task write_mode(logic value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		tbpe_pkg::cmd_t cmd;
		logic [7:0] data;
		int         phase_len;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Idle tick, byte load, ignored loads, then mode changes in the middle of a byte.
		write_mode(1'b0);
		send_item(tbpe_pkg::CMD_TICK, 8'h00);
		send_item(tbpe_pkg::CMD_LOAD, 8'hFF);
		send_item(tbpe_pkg::CMD_LOAD, 8'h00);
		repeat (3) send_item(tbpe_pkg::CMD_TICK, 8'hFF);
		write_mode(1'b1);
		repeat (3) send_item(tbpe_pkg::CMD_TICK, 8'h00);
		send_item(tbpe_pkg::CMD_LOAD, 8'h55);
		repeat (3) send_item(tbpe_pkg::CMD_TICK, 8'hAA);
		write_mode(1'b0);
		repeat (3) send_item(tbpe_pkg::CMD_TICK, 8'h00);

		item_count = 0;
		while (item_count < RandomItems) begin
			write_mode($urandom_range(0, 99) < 65);
			phase_len = $urandom_range(60, 300);
			repeat (phase_len) begin
				if (!sb.sending)
					cmd = ($urandom_range(0, 99) < 85) ? tbpe_pkg::CMD_LOAD
						: tbpe_pkg::CMD_TICK;
				else
					cmd = ($urandom_range(0, 99) < 3) ? tbpe_pkg::CMD_LOAD
						: tbpe_pkg::CMD_TICK;
				data = 8'($urandom_range(0, 255));
				if (!(cmd == tbpe_pkg::CMD_LOAD && sb.sending))
					item_count++;
				send_item(cmd, data);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d samples never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("tape_byte_pulse_encoder_core: match");
		end else begin
			$display("tape_byte_pulse_encoder_core: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tbpe_pkg.sv
rtl/tbpe_engine.sv
rtl/tape_byte_pulse_encoder_core.sv
rtl/tbpe_checker.sv
sim/tb_tape_byte_pulse_encoder_core.sv
